FILE: design/bafr_pkg.sv
// ----------------------------------------------------------------------------
// bafr_pkg
// Shared constants, codes and types of the pooled bump allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bafr_pkg;

  localparam int POOLS           = 4;
  localparam int POOL_BYTES      = 16777216;
  localparam int RING_DEPTH      = 256;
  localparam int BASE_REGS       = 4;
  localparam int REUSE_THRESHOLD = 2;

  localparam int ADDR_W  = 48;
  localparam int OFF_W   = 32;
  localparam int SIZE_W  = 25;
  localparam int LG_W    = 4;
  localparam int PAD_W   = 16;
  localparam int PIDX_W  = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int RIDX_W  = $clog2(RING_DEPTH);
  localparam int RAM_DEPTH = POOLS * RING_DEPTH;
  localparam int RAM_AW  = $clog2(RAM_DEPTH);

  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 64;
  localparam int IN_DW   = 80;
  localparam int IN_UW   = 4;
  localparam int OUT_DW  = 48;
  localparam int OUT_UW  = 3;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_ALIGNED = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BOUND = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    K_NOP,
    K_FREE,
    K_ALLOC,
    K_ALIGN
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [PIDX_W-1:0]   pool;
    logic [SIZE_W-1:0]   size;
    logic [LG_W-1:0]     lg;
    logic [ADDR_W-1:0]   faddr;
  } cmd_t;

  typedef logic [BASE_REGS-1:0][ADDR_W-1:0] base_arr_t;

  typedef struct packed {
    logic                we;
    logic [RAM_AW-1:0]   waddr;
    logic [ADDR_W-1:0]   wdata;
    logic [RAM_AW-1:0]   raddr;
  } ram_req_t;

endpackage

`default_nettype wire

FILE: design/bafr_ram.sv
// ----------------------------------------------------------------------------
// bafr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bafr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/bafr_front.sv
// ----------------------------------------------------------------------------
// bafr_front
// Input stage: takes request transfers, classifies them into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bafr_front import bafr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_DW-1:0] in_tdata,
  input  wire logic [IN_UW-1:0] in_tuser,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output cmd_t                  cmd
);

  logic  valid_r, valid_nxt;
  cmd_t  cmd_r, cmd_nxt;
  logic [1:0] op;
  logic [1:0] pool;

  assign op   = in_tuser[1:0];
  assign pool = in_tuser[3:2];

  assign in_tready = !valid_r || cmd_ready;

  always_comb begin
    cmd_nxt.pool  = PIDX_W'(pool);
    cmd_nxt.size  = in_tdata[24:0];
    cmd_nxt.lg    = in_tdata[28:25];
    cmd_nxt.faddr = in_tdata[76:29];
    unique case (op)
      OP_ALLOC:   cmd_nxt.kind = K_ALLOC;
      OP_ALIGNED: cmd_nxt.kind = K_ALIGN;
      OP_FREE:    cmd_nxt.kind = K_FREE;
      default:    cmd_nxt.kind = K_NOP;
    endcase
    // pools that do not exist do nothing
    if (int'(pool) >= POOLS) begin
      cmd_nxt.kind = K_NOP;
    end
    valid_nxt = (valid_r && !cmd_ready) || in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        valid_r <= valid_nxt;
      end
      if (in_tvalid && in_tready) begin
        cmd_r <= cmd_nxt;
      end
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire

FILE: design/bafr_queue.sv
// ----------------------------------------------------------------------------
// bafr_queue
// Two-entry command queue between the input stage and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module bafr_queue import bafr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  cmd_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_cmd    = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wptr_nxt = do_push ? !wptr_r : wptr_r;
    rptr_nxt = do_pop ? !rptr_r : rptr_r;
    fill_nxt = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
      if (do_push) begin
        slot_r[wptr_r] <= push_cmd;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/bafr_back.sv
// ----------------------------------------------------------------------------
// bafr_back
// Executor: per-pool bump offsets and free-ring pointers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bafr_back import bafr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  output logic                   cmd_pop,
  input  wire cmd_t              cmd,
  input  wire base_arr_t         bases,
  output ram_req_t               ram_req,
  input  wire logic [ADDR_W-1:0] ram_rdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,
  output logic [OUT_UW-1:0]      out_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PAD,
    S_ADV,
    S_SIZE,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [OFF_W-1:0]   off_r [POOLS];
  logic [OFF_W-1:0]   off_nxt [POOLS];
  logic [RIDX_W-1:0]  cnt_r [POOLS];
  logic [RIDX_W-1:0]  cnt_nxt [POOLS];
  logic [RIDX_W-1:0]  wi_r [POOLS];
  logic [RIDX_W-1:0]  wi_nxt [POOLS];
  logic [ADDR_W-1:0]  sum_r, sum_nxt;
  logic [PAD_W-1:0]   pad_r, pad_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [OFF_W-1:0]   noff_r, noff_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic               res_from_r, res_from_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic               out_from_r, out_from_nxt;
  logic [1:0]         out_st_r, out_st_nxt;

  logic [RIDX_W-1:0]  in_cnt, in_wi;
  logic [OFF_W-1:0]   in_off, new_off;
  logic [RIDX_W:0]    spot_tmp;
  logic [RIDX_W-1:0]  spot;
  logic [PAD_W:0]     one_sh;
  logic [PAD_W-1:0]   amask, low;

  function automatic logic [OFF_W-1:0] sat_add(input logic [OFF_W-1:0] a,
                                               input logic [OFF_W-1:0] b);
    logic [OFF_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OFF_W] ? {OFF_W{1'b1}} : s[OFF_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] base_of(input base_arr_t b,
                                                input logic [PIDX_W-1:0] p);
    logic [ADDR_W-1:0] v;
    v = '0;
    for (int i = 0; i < BASE_REGS; i++) begin
      if (int'(p) == i) begin
        v = b[i];
      end
    end
    return v;
  endfunction

  function automatic logic [RAM_AW-1:0] ram_addr(input logic [PIDX_W-1:0] p,
                                                 input logic [RIDX_W-1:0] idx);
    return RAM_AW'(int'(p) * RING_DEPTH + int'(idx));
  endfunction

  assign in_cnt = cnt_r[cmd.pool];
  assign in_wi  = wi_r[cmd.pool];
  assign in_off = off_r[cmd.pool];

  // oldest entry sits count places behind the write index
  assign spot_tmp = {1'b0, in_wi} + (RIDX_W+1)'(RING_DEPTH) - {1'b0, in_cnt};
  assign spot     = (spot_tmp >= (RIDX_W+1)'(RING_DEPTH)) ?
                    RIDX_W'(spot_tmp - (RIDX_W+1)'(RING_DEPTH)) : RIDX_W'(spot_tmp);

  assign one_sh = (PAD_W+1)'(1) << cmd_r.lg;
  assign amask  = PAD_W'(one_sh - (PAD_W+1)'(1));
  assign low    = sum_r[PAD_W-1:0] & amask;
  assign new_off = sat_add(noff_r, OFF_W'(cmd_r.size));

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    off_nxt       = off_r;
    cnt_nxt       = cnt_r;
    wi_nxt        = wi_r;
    sum_nxt       = sum_r;
    pad_nxt       = pad_r;
    addr_nxt      = addr_r;
    noff_nxt      = noff_r;
    res_addr_nxt  = res_addr_r;
    res_from_nxt  = res_from_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt  = out_addr_r;
    out_from_nxt  = out_from_r;
    out_st_nxt    = out_st_r;
    cmd_pop       = 1'b0;
    ram_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          cmd_nxt      = cmd;
          res_addr_nxt = '0;
          res_from_nxt = 1'b0;
          res_st_nxt   = ST_OK;
          unique case (cmd.kind)
            K_NOP: begin
              state_nxt = S_OUT;
            end
            K_FREE: begin
              state_nxt = S_OUT;
              if (in_cnt >= RIDX_W'(RING_DEPTH - 1)) begin
                res_st_nxt = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ram_addr(cmd.pool, in_wi);
                ram_req.wdata = cmd.faddr;
                wi_nxt[cmd.pool]  = (in_wi == RIDX_W'(RING_DEPTH - 1)) ?
                                    '0 : in_wi + RIDX_W'(1);
                cnt_nxt[cmd.pool] = in_cnt + RIDX_W'(1);
              end
            end
            K_ALLOC, K_ALIGN: begin
              if (cmd.kind == K_ALLOC && in_cnt > RIDX_W'(REUSE_THRESHOLD)) begin
                ram_req.raddr     = ram_addr(cmd.pool, spot);
                cnt_nxt[cmd.pool] = in_cnt - RIDX_W'(1);
                state_nxt         = S_POP;
              end else begin
                sum_nxt   = base_of(bases, cmd.pool) + ADDR_W'(in_off);
                state_nxt = S_PAD;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_POP: begin
        res_addr_nxt = ram_rdata;
        res_from_nxt = 1'b1;
        state_nxt    = S_OUT;
      end
      S_PAD: begin
        if (cmd_r.kind == K_ALIGN && low != '0) begin
          pad_nxt = PAD_W'(one_sh - {1'b0, low});
        end else begin
          pad_nxt = '0;
        end
        state_nxt = S_ADV;
      end
      S_ADV: begin
        addr_nxt  = sum_r + ADDR_W'(pad_r);
        noff_nxt  = sat_add(off_r[cmd_r.pool], OFF_W'(pad_r));
        state_nxt = S_SIZE;
      end
      S_SIZE: begin
        off_nxt[cmd_r.pool] = new_off;
        res_addr_nxt = addr_r;
        res_st_nxt   = (new_off > OFF_W'(POOL_BYTES)) ? ST_BOUND : ST_OK;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_from_nxt  = res_from_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < POOLS; i++) begin
        off_r[i] <= '0;
        cnt_r[i] <= '0;
        wi_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      off_r       <= off_nxt;
      cnt_r       <= cnt_nxt;
      wi_r        <= wi_nxt;
      cmd_r       <= cmd_nxt;
      sum_r       <= sum_nxt;
      pad_r       <= pad_nxt;
      addr_r      <= addr_nxt;
      noff_r      <= noff_nxt;
      res_addr_r  <= res_addr_nxt;
      res_from_r  <= res_from_nxt;
      res_st_r    <= res_st_nxt;
      out_addr_r  <= out_addr_nxt;
      out_from_r  <= out_from_nxt;
      out_st_r    <= out_st_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = {out_st_r, out_from_r};

endmodule

`default_nettype wire

FILE: design/bump_allocator_free_ring.sv
// ----------------------------------------------------------------------------
// bump_allocator_free_ring
// Multi-pool bump allocator with a FIFO ring of freed addresses per pool.
// ----------------------------------------------------------------------------
// Requests enter through a classifying input stage and a two-entry command
// queue, so new transfers are taken while the executor works. The executor
// handles one command at a time: a free or an ignored request goes straight
// to the result state, a reuse from the free ring waits in a pop state for
// the registered read of the ring memory, and a bump allocation steps through
// base add, alignment pad, pad advance, size advance and result. The result
// register holds one finished result until it is taken. Pool bases are written
// over the register port; the ring memory needs no clearing after reset.
`default_nettype none

module bump_allocator_free_ring import bafr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  // requests
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // request_bytes[24:0], align_log2[28:25], freed_address[76:29], zero fill
  input  wire logic [IN_DW-1:0]  in_tdata,
  // operation[1:0], pool[3:2]
  input  wire logic [IN_UW-1:0]  in_tuser,
  // results
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // address[47:0]
  output logic      [OUT_DW-1:0] out_tdata,
  // from_free_ring[0], status[2:1]
  output logic      [OUT_UW-1:0] out_tuser
);

  base_arr_t         base_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  logic              f_valid, f_ready;
  cmd_t              f_cmd;
  logic              q_valid, q_pop;
  cmd_t              q_cmd;
  ram_req_t          ram_req;
  logic [ADDR_W-1:0] ram_rdata;

  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DW'(base_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_wr) begin
      base_r[reg_idx] <= cfg_pwdata[ADDR_W-1:0];
    end
  end

  bafr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bafr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  bafr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_pop    (q_pop),
    .cmd        (q_cmd),
    .bases      (base_r),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  bafr_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: verif/bafr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bafr_checker
// Watches the register, request and result ports of the pooled allocator,
// keeps its own copy of pool bases, bump offsets and free rings, works out
// the grant for every request transfer and compares each result transfer
// with the oldest grant still owed.
// ----------------------------------------------------------------------------
module bafr_checker import bafr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [IN_UW-1:0]  in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic [OUT_UW-1:0] out_tuser,
  output int                mismatch_count,
  output int                grants_owed
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              from_ring;
    logic [1:0]        status;
  } grant_t;

  logic [ADDR_W-1:0] base_reg [BASE_REGS];
  logic [63:0]       bump_off [POOLS];
  logic [ADDR_W-1:0] ring_mem [POOLS][RING_DEPTH];
  logic [RIDX_W-1:0] ring_wr [POOLS];
  logic [RIDX_W:0]   ring_fill [POOLS];
  grant_t            grant_q [$];
  grant_t            want;
  grant_t            got;
  int                fails;
  int                reg_idx;

  function automatic logic [63:0] capped_offset(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'h0000_0000_FFFF_FFFF) ? 64'h0000_0000_FFFF_FFFF : s;
  endfunction

  task automatic compute_grant(input logic [1:0] op, input logic [PIDX_W-1:0] pl,
                               input logic [SIZE_W-1:0] sz, input logic [LG_W-1:0] lg,
                               input logic [ADDR_W-1:0] fa, output grant_t g);
    logic [63:0]       off;
    logic [63:0]       amask;
    logic [63:0]       low;
    logic [ADDR_W-1:0] addr;
    logic [RIDX_W-1:0] spot;
    g = '0;
    if (op == OP_FREE) begin
      if (ring_fill[pl] >= RING_DEPTH - 1) begin
        g.status = ST_FULL;
      end else begin
        ring_mem[pl][ring_wr[pl]] = fa;
        ring_wr[pl] = ring_wr[pl] + 1'b1;
        ring_fill[pl] = ring_fill[pl] + 1'b1;
      end
    end else if (op == OP_ALLOC && ring_fill[pl] > REUSE_THRESHOLD) begin
      // oldest entry sits ring_fill slots behind the write pointer
      spot = ring_wr[pl] - ring_fill[pl][RIDX_W-1:0];
      g.addr = ring_mem[pl][spot];
      g.from_ring = 1'b1;
      ring_fill[pl] = ring_fill[pl] - 1'b1;
    end else if (op != OP_UNUSED) begin
      off = bump_off[pl];
      addr = base_reg[pl] + off[ADDR_W-1:0];
      if (op == OP_ALIGNED) begin
        amask = (64'd1 << lg) - 64'd1;
        low = {16'd0, addr} & amask;
        if (low != 64'd0) begin
          addr = addr + ADDR_W'(amask + 64'd1 - low);
          off = capped_offset(off, amask + 64'd1 - low);
        end
      end
      off = capped_offset(off, 64'(sz));
      bump_off[pl] = off;
      g.addr = addr;
      if (off > 64'(POOL_BYTES)) g.status = ST_BOUND;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < POOLS; p++) begin
        bump_off[p] = '0;
        ring_wr[p] = '0;
        ring_fill[p] = '0;
      end
      for (int r = 0; r < BASE_REGS; r++) base_reg[r] = '0;
      grant_q.delete();
      fails = 0;
      grants_owed <= 0;
      mismatch_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        reg_idx = int'(cfg_paddr >> 3);
        if (reg_idx < BASE_REGS) base_reg[reg_idx] = cfg_pwdata[ADDR_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        compute_grant(in_tuser[1:0], in_tuser[3:2], in_tdata[SIZE_W-1:0],
                      in_tdata[SIZE_W+LG_W-1:SIZE_W],
                      in_tdata[SIZE_W+LG_W+ADDR_W-1:SIZE_W+LG_W], want);
        grant_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.addr = out_tdata[ADDR_W-1:0];
        got.from_ring = out_tuser[0];
        got.status = out_tuser[2:1];
        if (grant_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: result transfer with no grant owed: addr %h ring %0d st %0d",
                     $realtime, got.addr, got.from_ring, got.status);
          fails++;
        end else begin
          want = grant_q.pop_front();
          if (got.addr != want.addr || got.from_ring != want.from_ring ||
              got.status != want.status) begin
            if (fails < 10)
              $display("%0t: grant mismatch (exp/got): addr %h/%h ring %0d/%0d st %0d/%0d",
                       $realtime, want.addr, got.addr, want.from_ring, got.from_ring,
                       want.status, got.status);
            fails++;
          end
        end
      end
      grants_owed <= grant_q.size();
      mismatch_count <= fails;
    end
  end

endmodule

FILE: verif/tb_bump_allocator_free_ring.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bump_allocator_free_ring
// Drives the pooled allocator with directed corner requests, then phases of
// random mixed traffic, a free ring filled past capacity and a pool grown
// until its offset saturates; pool bases change between phases.
// ----------------------------------------------------------------------------
module tb_bump_allocator_free_ring;
  import bafr_pkg::*;

  localparam int REG_BASE_0 = 0;
  localparam int REG_BASE_1 = 1;
  localparam int REG_BASE_2 = 2;
  localparam int REG_BASE_3 = 3;
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(POOL_BYTES);

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // request_bytes[24:0], align_log2[28:25], freed_address[76:29], zero fill
  logic [IN_DW-1:0]  in_tdata = '0;
  // operation[1:0], pool[3:2]
  logic [IN_UW-1:0]  in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // address[47:0]
  logic [OUT_DW-1:0] out_tdata;
  // from_free_ring[0], status[2:1]
  logic [OUT_UW-1:0] out_tuser;
  int                mismatch_count;
  int                grants_owed;
  int                burst_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bump_allocator_free_ring uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  bafr_checker grant_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .grants_owed    (grants_owed)
  );

  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return SIZE_W'($urandom_range(0, 4096));
    if (roll < 8) return SIZE_W'($urandom_range(0, 1 << 20));
    if (roll < 9) return SIZE_W'($urandom_range(0, POOL_BYTES));
    return SIZE_MAX;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // setup and access phases, then the bus is released
  task automatic write_base(input int idx, input logic [CFG_DW-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(idx * 8);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic issue_request(input logic [1:0] op, input logic [PIDX_W-1:0] pl,
                               input logic [SIZE_W-1:0] sz, input logic [LG_W-1:0] lg,
                               input logic [ADDR_W-1:0] fa);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DW-SIZE_W-LG_W-ADDR_W){1'b0}}, fa, lg, sz};
    in_tuser <= {pl, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic random_request();
    int roll;
    logic [1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 35) op = OP_ALLOC;
    else if (roll < 60) op = OP_ALIGNED;
    else if (roll < 95) op = OP_FREE;
    else op = OP_UNUSED;
    issue_request(op, PIDX_W'($urandom_range(0, POOLS - 1)), pick_size(),
                  LG_W'($urandom_range(0, 15)), pick_addr());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (grants_owed != 0) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_base(REG_BASE_0, '0);
    write_base(REG_BASE_1, '1);
    write_base(REG_BASE_2, 64'h0000_1234_5678_9abd);
    write_base(REG_BASE_3, {$urandom(), $urandom()});
    issue_request(OP_ALLOC, 0, '0, '0, '0);
    issue_request(OP_ALLOC, 0, SIZE_MAX, '0, '0);   // lands exactly on the bound
    issue_request(OP_ALLOC, 0, 1, '0, '0);          // one byte past it
    issue_request(OP_ALIGNED, 1, 5, 0, '0);
    issue_request(OP_ALIGNED, 1, 3, 15, '0);        // pad carries past the top
    issue_request(OP_ALIGNED, 2, 100, 12, '0);
    issue_request(OP_ALIGNED, 2, 7, 13, '0);
    issue_request(OP_ALIGNED, 2, '0, 14, '0);
    issue_request(OP_UNUSED, 3, SIZE_MAX, '1, '1);
    issue_request(OP_FREE, 3, '0, '0, '0);
    issue_request(OP_FREE, 3, SIZE_MAX, '1, '1);
    issue_request(OP_FREE, 3, '0, '0, pick_addr());
    issue_request(OP_FREE, 3, '0, '0, pick_addr());
    issue_request(OP_ALLOC, 3, 64, '0, '0);
    issue_request(OP_ALLOC, 3, 64, '0, '0);
    issue_request(OP_ALLOC, 3, 64, '0, '0);         // two left in the ring, so it bumps
    issue_request(OP_FREE, 3, '0, '0, pick_addr());
    issue_request(OP_ALIGNED, 3, 64, 6, '0);        // aligned never reuses
    issue_request(OP_ALLOC, 3, 64, '0, '0);
    issue_request(OP_ALIGNED, 0, SIZE_MAX, 15, '0);
    issue_request(OP_FREE, 1, '0, '0, 48'h8000_0000_0001);
    drain();

    for (int r = REG_BASE_0; r <= REG_BASE_3; r++) write_base(r, {$urandom(), $urandom()});
    repeat (80) random_request();
    drain();

    // fill one ring past capacity, then pull the oldest entries back out
    write_base(REG_BASE_2, '0);
    for (int n = 0; n < 262; n++) begin
      if ($urandom_range(0, 19) == 0) random_request();
      else issue_request(OP_FREE, 2, pick_size(), LG_W'($urandom_range(0, 15)), pick_addr());
    end
    for (int n = 0; n < 15; n++) begin
      if ($urandom_range(0, 4) == 0) random_request();
      else issue_request(OP_ALLOC, 2, pick_size(), LG_W'($urandom_range(0, 15)), '0);
    end
    drain();

    // near-maximum aligned allocs until the offset pins at its ceiling
    write_base(REG_BASE_1, 64'h0000_ffff_ffff_f000);
    for (int n = 0; n < 275; n++) begin
      if ($urandom_range(0, 24) == 0) random_request();
      else issue_request(OP_ALIGNED, 1, SIZE_W'($urandom_range(16000000, POOL_BYTES)),
                         LG_W'($urandom_range(0, 15)), pick_addr());
    end
    drain();

    write_base(REG_BASE_0, '1);
    write_base(REG_BASE_1, '0);
    write_base(REG_BASE_2, '1);
    write_base(REG_BASE_3, '0);
    repeat (50) random_request();
    drain();
    repeat (16) @(posedge clk);

    if (mismatch_count == 0 && grants_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int style;
    int k;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    repeat (60) begin
      @(posedge clk);
      out_tready <= 1'($urandom_range(0, 1));
    end
    // long hold-off: results back up until the input side stalls
    @(posedge clk);
    out_tready <= 1'b0;
    repeat (299) @(posedge clk);
    forever begin
      style = $urandom_range(0, 2);
      k = $urandom_range(2, 5);
      for (int c = 0; c < 64; c++) begin
        @(posedge clk);
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 99) < 60);
          default: out_tready <= (c % k == 0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
